[rtl/arp_resolution_cache_top_macros.svh]
// ----------------------------------------------------------------------------
// ARP resolution cache assertion macros
// Concurrent assertion wrappers clocked on clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ARP_RESOLUTION_CACHE_TOP_MACROS_SVH
`define ARP_RESOLUTION_CACHE_TOP_MACROS_SVH

`ifndef SYNTH
`define ARPC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("arpc assertion failed");
`define ARPC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("arpc implication failed");
`else
`define ARPC_ASSERT(label, prop)
`define ARPC_ASSERT_IMPL(label, ante, cons)
`endif

`endif

[rtl/arpc_pkg.sv]
// ----------------------------------------------------------------------------
// ARP resolution cache package
// Payload types, command and result codes, shared constants.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEF_TABLE_ENTRIES     = 16;
    localparam int DEF_WAITERS_PER_ENTRY = 8;

    localparam int CFG_ADDR_W = 5;

    localparam logic [1:0] REG_OWN_IP      = 2'd0;
    localparam logic [1:0] REG_OWN_MAC     = 2'd1;
    localparam logic [1:0] REG_INIT_TIMEOUT = 2'd2;
    localparam logic [1:0] REG_MAX_TIMEOUT = 2'd3;

    localparam logic [31:0] RST_INIT_TIMEOUT = 32'd1000;
    localparam logic [31:0] RST_MAX_TIMEOUT  = 32'd64000;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_PACKET = 2'd1;
    localparam logic [1:0] CMD_EXPIRY = 2'd2;

    localparam logic [15:0] ARP_HW_ETH     = 16'd1;
    localparam logic [15:0] ARP_PROTO_IPV4 = 16'h0800;
    localparam logic [7:0]  ARP_HW_LEN     = 8'd6;
    localparam logic [7:0]  ARP_PROTO_LEN  = 8'd4;
    localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
    localparam logic [47:0] BCAST_MAC      = 48'hffff_ffff_ffff;

    localparam logic [3:0] KIND_HIT      = 4'd0;
    localparam logic [3:0] KIND_QUEUED   = 4'd1;
    localparam logic [3:0] KIND_SEND_REQ = 4'd2;
    localparam logic [3:0] KIND_REPLY    = 4'd3;
    localparam logic [3:0] KIND_RESOLVED = 4'd4;
    localparam logic [3:0] KIND_FAILED   = 4'd5;
    localparam logic [3:0] KIND_CANCEL   = 4'd6;
    localparam logic [3:0] KIND_IGNORED  = 4'd7;
    localparam logic [3:0] KIND_FULL     = 4'd8;
    localparam logic [3:0] KIND_UPDATED  = 4'd9;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] query_ip;
        logic [7:0]  waiter_id;
        logic [15:0] hw_type;
        logic [15:0] proto_type;
        logic [7:0]  hw_len;
        logic [7:0]  proto_len;
        logic [15:0] operation;
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } arpc_req_t;

    typedef struct packed {
        logic [3:0]  result_kind;
        logic [7:0]  waiter;
        logic [31:0] peer_ip;
        logic [47:0] peer_mac;
        logic [31:0] timer_value;
        logic        last;
    } arpc_rsp_t;

    typedef enum logic [2:0] {
        OP_LOOKUP,
        OP_LOOKUP_OWN,
        OP_ANSWER,
        OP_REPLY,
        OP_EXPIRY,
        OP_IGNORE
    } arpc_op_t;

    typedef struct packed {
        arpc_op_t    op;
        logic [31:0] ip;
        logic [7:0]  waiter;
        logic [47:0] mac;
    } arpc_job_t;

    typedef struct packed {
        logic [31:0] own_ip;
        logic [47:0] own_mac;
        logic [31:0] init_timeout;
        logic [31:0] max_timeout;
    } arpc_cfg_t;

    typedef struct packed {
        logic [1:0] count;
        logic       full;
        logic       empty;
    } arpc_q_status_t;

    typedef struct packed {
        logic busy;
    } arpc_back_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EMIT_A,
        ST_EMIT_B,
        ST_WREAD,
        ST_WEMIT
    } arpc_state_t;

    function automatic arpc_rsp_t make_rsp(input logic [3:0] kind, input logic [7:0] w,
                                           input logic [31:0] ip, input logic [47:0] mac,
                                           input logic [31:0] tmr);
        arpc_rsp_t r;
        r.result_kind = kind;
        r.waiter      = w;
        r.peer_ip     = ip;
        r.peer_mac    = mac;
        r.timer_value = tmr;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

[rtl/arpc_front.sv]
// ----------------------------------------------------------------------------
// ARP resolution cache front end
// Checks packet headers and sorts each beat into a job class for the back end.
// ----------------------------------------------------------------------------
module arpc_front (
    input  arpc_pkg::arpc_req_t req,
    input  arpc_pkg::arpc_cfg_t cfg,
    output arpc_pkg::arpc_job_t job
);
    import arpc_pkg::*;

    logic hdr_ok;

    assign hdr_ok = (req.hw_type == ARP_HW_ETH) && (req.proto_type == ARP_PROTO_IPV4) &&
                    (req.hw_len == ARP_HW_LEN) && (req.proto_len == ARP_PROTO_LEN);

    always_comb
    begin
        job.op     = OP_IGNORE;
        job.ip     = req.query_ip;
        job.waiter = req.waiter_id;
        job.mac    = req.sender_mac;
        unique case (req.command)
            CMD_LOOKUP:
            begin
                job.op = (req.query_ip == cfg.own_ip) ? OP_LOOKUP_OWN : OP_LOOKUP;
            end
            CMD_PACKET:
            begin
                job.ip = req.sender_ip;
                priority if (!hdr_ok)
                begin
                    job.op = OP_IGNORE;
                end
                else if (req.operation == ARP_OP_REQUEST)
                begin
                    job.op = (req.target_ip == cfg.own_ip) ? OP_ANSWER : OP_IGNORE;
                end
                else if (req.operation == ARP_OP_REPLY && req.sender_ip != cfg.own_ip)
                begin
                    job.op = OP_REPLY;
                end
                else
                begin
                    job.op = OP_IGNORE;
                end
            end
            CMD_EXPIRY:
            begin
                job.op = OP_EXPIRY;
            end
            default:
            begin
                job.op = OP_IGNORE;
            end
        endcase
    end

endmodule

[rtl/arpc_fifo.sv]
// ----------------------------------------------------------------------------
// ARP resolution cache job queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module arpc_fifo (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  arpc_pkg::arpc_job_t      push_data,
    input  logic                     pop,
    output arpc_pkg::arpc_job_t      head,
    output arpc_pkg::arpc_q_status_t status
);
    import arpc_pkg::*;

    arpc_job_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign status.count = count_reg;
    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign head         = mem_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/arpc_back.sv]
// ----------------------------------------------------------------------------
// ARP resolution cache back end
// Table scan, entry updates, waiter lists and result sequencing.
// ----------------------------------------------------------------------------
module arpc_back #(
    parameter int TABLE_ENTRIES     = arpc_pkg::DEF_TABLE_ENTRIES,
    parameter int WAITERS_PER_ENTRY = arpc_pkg::DEF_WAITERS_PER_ENTRY
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  arpc_pkg::arpc_cfg_t         cfg,
    input  arpc_pkg::arpc_job_t         job,
    input  logic                        job_avail,
    output logic                        job_pop,
    input  logic                        rsp_stall,
    output logic                        rsp_valid,
    output arpc_pkg::arpc_rsp_t         rsp_data,
    output arpc_pkg::arpc_back_status_t status
);
    import arpc_pkg::*;

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int CNT_W    = $clog2(WAITERS_PER_ENTRY + 1);
    localparam int WS_DEPTH = TABLE_ENTRIES * WAITERS_PER_ENTRY;
    localparam int WA_W     = $clog2(WS_DEPTH);

    arpc_state_t state_reg, state_next;
    arpc_job_t   job_reg;

    logic [IDX_W-1:0] scan_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic             free_reg;
    logic [IDX_W-1:0] free_idx_reg;

    logic             entry_valid_reg   [TABLE_ENTRIES];
    logic             entry_pending_reg [TABLE_ENTRIES];
    logic [CNT_W-1:0] waiter_count_reg  [TABLE_ENTRIES];
    logic [31:0]      entry_ip_reg      [TABLE_ENTRIES];
    logic [47:0]      entry_mac_reg     [TABLE_ENTRIES];
    logic [31:0]      entry_timeout_reg [TABLE_ENTRIES];

    logic [7:0]       ws_mem [WS_DEPTH];
    logic [7:0]       ws_rdata_reg;

    arpc_rsp_t        hd_a_reg, hd_b_reg;
    logic             has_b_reg;
    logic [3:0]       loop_kind_reg;
    logic [47:0]      loop_mac_reg;
    logic [CNT_W-1:0] loop_cnt_reg;
    logic [WA_W-1:0]  loop_base_reg;

    logic             out_valid_reg;
    arpc_rsp_t        out_data_reg;

    // decision signals
    arpc_rsp_t        dec_a, dec_b;
    logic             dec_has_a, dec_has_b;
    logic [3:0]       dec_loop_kind;
    logic [47:0]      dec_loop_mac;
    logic [CNT_W-1:0] dec_loop_cnt;
    logic             do_alloc, do_queue, do_fill, do_resolve, do_drop, do_retry;
    logic [32:0]      dbl;
    logic             ws_we;
    logic [WA_W-1:0]  ws_waddr;
    logic [WA_W-1:0]  ws_raddr;
    logic [WA_W-1:0]  hit_base;

    logic             load_ok, out_load, cur_match, scan_last, needs_scan;
    arpc_rsp_t        out_load_data;
    logic [CNT_W-1:0] cnt_e;

    assign status.busy = (state_reg != ST_IDLE);
    assign rsp_valid   = out_valid_reg;
    assign rsp_data    = out_data_reg;
    assign job_pop     = (state_reg == ST_IDLE) && job_avail;

    assign load_ok    = !out_valid_reg || !rsp_stall;
    assign needs_scan = (job.op == OP_LOOKUP) || (job.op == OP_REPLY) || (job.op == OP_EXPIRY);
    assign cur_match  = entry_valid_reg[scan_idx_reg] &&
                        (entry_ip_reg[scan_idx_reg] == job_reg.ip);
    assign scan_last  = (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1));
    assign cnt_e      = waiter_count_reg[hit_idx_reg];
    assign hit_base   = WA_W'(hit_idx_reg) * WA_W'(WAITERS_PER_ENTRY);
    assign dbl        = {entry_timeout_reg[hit_idx_reg], 1'b0};
    assign ws_raddr   = loop_base_reg + WA_W'(loop_cnt_reg - CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_avail)
                begin
                    state_next = needs_scan ? ST_SCAN : ST_DECIDE;
                end
            end
            ST_SCAN:
            begin
                if (cur_match || scan_last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                state_next = dec_has_a ? ST_EMIT_A : ST_WREAD;
            end
            ST_EMIT_A:
            begin
                if (load_ok)
                begin
                    priority if (has_b_reg)
                        state_next = ST_EMIT_B;
                    else if (loop_cnt_reg != '0)
                        state_next = ST_WREAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_EMIT_B:
            begin
                if (load_ok)
                begin
                    state_next = (loop_cnt_reg != '0) ? ST_WREAD : ST_IDLE;
                end
            end
            ST_WREAD:
            begin
                state_next = ST_WEMIT;
            end
            ST_WEMIT:
            begin
                if (load_ok)
                begin
                    state_next = (loop_cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_WREAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: what a decided job does and which result is loaded
    always_comb
    begin
        dec_a         = make_rsp(KIND_IGNORED, 8'd0, 32'd0, 48'd0, 32'd0);
        dec_b         = make_rsp(KIND_IGNORED, 8'd0, 32'd0, 48'd0, 32'd0);
        dec_has_a     = 1'b1;
        dec_has_b     = 1'b0;
        dec_loop_kind = KIND_RESOLVED;
        dec_loop_mac  = 48'd0;
        dec_loop_cnt  = '0;
        do_alloc      = 1'b0;
        do_queue      = 1'b0;
        do_fill       = 1'b0;
        do_resolve    = 1'b0;
        do_drop       = 1'b0;
        do_retry      = 1'b0;
        unique case (job_reg.op)
            OP_LOOKUP_OWN:
                dec_a = make_rsp(KIND_HIT, job_reg.waiter, job_reg.ip, cfg.own_mac, 32'd0);
            OP_ANSWER:
                dec_a = make_rsp(KIND_REPLY, 8'd0, job_reg.ip, job_reg.mac, 32'd0);
            OP_LOOKUP:
            begin
                priority if (hit_reg && !entry_pending_reg[hit_idx_reg])
                begin
                    dec_a = make_rsp(KIND_HIT, job_reg.waiter, job_reg.ip,
                                     entry_mac_reg[hit_idx_reg], 32'd0);
                end
                else if (hit_reg && cnt_e < CNT_W'(WAITERS_PER_ENTRY))
                begin
                    do_queue = 1'b1;
                    dec_a = make_rsp(KIND_QUEUED, job_reg.waiter, job_reg.ip, 48'd0, 32'd0);
                end
                else if (!hit_reg && free_reg)
                begin
                    do_alloc  = 1'b1;
                    dec_a     = make_rsp(KIND_QUEUED, job_reg.waiter, job_reg.ip, 48'd0, 32'd0);
                    dec_has_b = 1'b1;
                    dec_b     = make_rsp(KIND_SEND_REQ, 8'd0, job_reg.ip, BCAST_MAC,
                                         cfg.init_timeout);
                end
                else
                begin
                    dec_a = make_rsp(KIND_FULL, job_reg.waiter, job_reg.ip, 48'd0, 32'd0);
                end
            end
            OP_REPLY:
            begin
                if (hit_reg)
                begin
                    do_fill = 1'b1;
                    if (!entry_pending_reg[hit_idx_reg])
                    begin
                        dec_a = make_rsp(KIND_UPDATED, 8'd0, job_reg.ip, job_reg.mac, 32'd0);
                    end
                    else
                    begin
                        do_resolve    = 1'b1;
                        dec_a         = make_rsp(KIND_CANCEL, 8'd0, job_reg.ip, 48'd0, 32'd0);
                        dec_loop_kind = KIND_RESOLVED;
                        dec_loop_mac  = job_reg.mac;
                        dec_loop_cnt  = cnt_e;
                    end
                end
            end
            OP_EXPIRY:
            begin
                if (hit_reg && entry_pending_reg[hit_idx_reg])
                begin
                    if (dbl >= {1'b0, cfg.max_timeout})
                    begin
                        // give up: fail every waiter, newest first
                        do_drop       = 1'b1;
                        dec_loop_kind = KIND_FAILED;
                        dec_loop_cnt  = cnt_e;
                        dec_has_a     = (cnt_e == '0);
                    end
                    else
                    begin
                        do_retry = 1'b1;
                        dec_a    = make_rsp(KIND_SEND_REQ, 8'd0, job_reg.ip, BCAST_MAC,
                                            dbl[31:0]);
                    end
                end
            end
            default:
            begin
                dec_has_a = 1'b1;
            end
        endcase

        ws_we    = (state_reg == ST_DECIDE) && (do_queue || do_alloc);
        ws_waddr = do_alloc ? WA_W'(free_idx_reg) * WA_W'(WAITERS_PER_ENTRY)
                            : hit_base + WA_W'(cnt_e);

        out_load      = 1'b0;
        out_load_data = hd_a_reg;
        unique case (state_reg)
            ST_EMIT_A:
            begin
                out_load           = load_ok;
                out_load_data      = hd_a_reg;
                out_load_data.last = !has_b_reg && (loop_cnt_reg == '0);
            end
            ST_EMIT_B:
            begin
                out_load           = load_ok;
                out_load_data      = hd_b_reg;
                out_load_data.last = (loop_cnt_reg == '0);
            end
            ST_WEMIT:
            begin
                out_load           = load_ok;
                out_load_data      = make_rsp(loop_kind_reg, ws_rdata_reg, job_reg.ip,
                                              loop_mac_reg, 32'd0);
                out_load_data.last = (loop_cnt_reg == CNT_W'(1));
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            scan_idx_reg  <= '0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            has_b_reg     <= 1'b0;
            loop_cnt_reg  <= '0;
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                entry_valid_reg[i]   <= 1'b0;
                entry_pending_reg[i] <= 1'b0;
                waiter_count_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;

            if (job_pop)
            begin
                scan_idx_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                if (cur_match)
                    hit_reg <= 1'b1;
                if (!free_reg && !entry_valid_reg[scan_idx_reg])
                    free_reg <= 1'b1;
            end

            if (state_reg == ST_DECIDE)
            begin
                has_b_reg    <= dec_has_b;
                loop_cnt_reg <= dec_loop_cnt;
                if (do_alloc)
                begin
                    entry_valid_reg[free_idx_reg]   <= 1'b1;
                    entry_pending_reg[free_idx_reg] <= 1'b1;
                    waiter_count_reg[free_idx_reg]  <= CNT_W'(1);
                end
                if (do_queue)
                    waiter_count_reg[hit_idx_reg] <= cnt_e + CNT_W'(1);
                if (do_resolve)
                begin
                    entry_pending_reg[hit_idx_reg] <= 1'b0;
                    waiter_count_reg[hit_idx_reg]  <= '0;
                end
                if (do_drop)
                begin
                    entry_valid_reg[hit_idx_reg]   <= 1'b0;
                    entry_pending_reg[hit_idx_reg] <= 1'b0;
                    waiter_count_reg[hit_idx_reg]  <= '0;
                end
            end
            else if (state_reg == ST_WEMIT && load_ok)
            begin
                loop_cnt_reg <= loop_cnt_reg - CNT_W'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (job_pop)
            job_reg <= job;
        if (state_reg == ST_SCAN)
        begin
            if (cur_match)
                hit_idx_reg <= scan_idx_reg;
            if (!free_reg && !entry_valid_reg[scan_idx_reg])
                free_idx_reg <= scan_idx_reg;
        end
        if (state_reg == ST_DECIDE)
        begin
            hd_a_reg      <= dec_a;
            hd_b_reg      <= dec_b;
            loop_kind_reg <= dec_loop_kind;
            loop_mac_reg  <= dec_loop_mac;
            loop_base_reg <= hit_base;
            if (do_alloc)
            begin
                entry_ip_reg[free_idx_reg]      <= job_reg.ip;
                entry_mac_reg[free_idx_reg]     <= 48'd0;
                entry_timeout_reg[free_idx_reg] <= cfg.init_timeout;
            end
            if (do_fill)
                entry_mac_reg[hit_idx_reg] <= job_reg.mac;
            if (do_retry)
                entry_timeout_reg[hit_idx_reg] <= dbl[31:0];
        end
        if (out_load)
            out_data_reg <= out_load_data;
    end

    // waiter list memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ws_we)
            ws_mem[ws_waddr] <= job_reg.waiter;
        if (state_reg == ST_WREAD)
            ws_rdata_reg <= ws_mem[ws_raddr];
    end

endmodule

[rtl/arp_resolution_cache_top.sv]
// ----------------------------------------------------------------------------
// ARP resolution cache top level
// ARP resolver with a bounded address table, waiter lists and retry timing.
// ----------------------------------------------------------------------------
// One item is worked on at a time. A lookup, a reply or an expiry walks the
// table one entry per cycle until it hits or reaches the last entry, then
// goes through a decide step, emits its fixed results and then each released
// waiter (waiter memory read, then emit). An output stall holds any emit.
// Items that need no table walk go straight from idle to the decide step. A
// two-entry queue takes new items while the back end is busy. Configuration
// goes over the APB port at byte addresses 0, 8, 16, 24 with 64-bit data.

`include "arp_resolution_cache_top_macros.svh"

module arp_resolution_cache_top #(
    parameter int TABLE_ENTRIES     = arpc_pkg::DEF_TABLE_ENTRIES,
    parameter int WAITERS_PER_ENTRY = arpc_pkg::DEF_WAITERS_PER_ENTRY
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [arpc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]                     pwdata,
    output logic [63:0]                     prdata,
    output logic                            pready,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  arpc_pkg::arpc_req_t             req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output arpc_pkg::arpc_rsp_t             rsp_data
);
    import arpc_pkg::*;

    arpc_cfg_t         cfg_reg;
    arpc_job_t         front_job, head_job;
    arpc_q_status_t    q_stat;
    arpc_back_status_t back_stat;
    logic              cfg_we, job_pop;
    logic [1:0]        reg_sel;

    assign pready    = 1'b1;
    assign cfg_we    = psel && penable && pwrite;
    assign reg_sel   = paddr[CFG_ADDR_W-1:3];
    assign req_stall = q_stat.full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.own_ip       <= 32'd0;
            cfg_reg.own_mac      <= 48'd0;
            cfg_reg.init_timeout <= RST_INIT_TIMEOUT;
            cfg_reg.max_timeout  <= RST_MAX_TIMEOUT;
        end
        else if (cfg_we)
        begin
            unique case (reg_sel)
                REG_OWN_IP:       cfg_reg.own_ip       <= pwdata[31:0];
                REG_OWN_MAC:      cfg_reg.own_mac      <= pwdata[47:0];
                REG_INIT_TIMEOUT: cfg_reg.init_timeout <= pwdata[31:0];
                REG_MAX_TIMEOUT:  cfg_reg.max_timeout  <= pwdata[31:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_OWN_IP:       prdata = {32'd0, cfg_reg.own_ip};
            REG_OWN_MAC:      prdata = {16'd0, cfg_reg.own_mac};
            REG_INIT_TIMEOUT: prdata = {32'd0, cfg_reg.init_timeout};
            REG_MAX_TIMEOUT:  prdata = {32'd0, cfg_reg.max_timeout};
        endcase
    end

    arpc_front u_front (
        .req (req_data),
        .cfg (cfg_reg),
        .job (front_job)
    );

    arpc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (req_valid),
        .push_data (front_job),
        .pop       (job_pop),
        .head      (head_job),
        .status    (q_stat)
    );

    arpc_back #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .WAITERS_PER_ENTRY (WAITERS_PER_ENTRY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job       (head_job),
        .job_avail (!q_stat.empty),
        .job_pop   (job_pop),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data),
        .status    (back_stat)
    );

    // a beat that is not the last of its item means the back end still owes more
    `ARPC_ASSERT_IMPL(a_more_pending, rsp_valid && !rsp_data.last, back_stat.busy)
    // the back end only starts work on a queued job
    `ARPC_ASSERT_IMPL(a_start_from_queue, $rose(back_stat.busy), $past(!q_stat.empty))
    `ARPC_ASSERT(a_queue_bound, q_stat.count != 2'd3)

endmodule
